FILE: rtl/rbre_pkg.sv
`timescale 1ns / 1ps
package rbre_pkg;
    localparam int SHAPE_COUNT_DEF = 16;
    localparam logic [31:0] GROUP_RESET = 32'd1;
    localparam logic [31:0] SCALE_RESET = 32'd32768;
    localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_PART = 1'b1
    } t_opcode;

    typedef enum logic [0:0] {
        CFG_GROUP = 1'b0,
        CFG_SCALE = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_QMUL,
        ST_ROT,
        ST_SQR,
        ST_DIV,
        ST_ACC,
        ST_SCALE,
        ST_OUT
    } t_state;

    // serial multiplier command and status
    typedef struct packed {
        logic start;
    } t_mul_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_sts;

    function automatic logic signed [31:0] clampq(input logic signed [31:0] v);
        logic signed [31:0] r;
        r = v;
        if (v > 32'sd1073741824) r = 32'sd1073741824;
        if (v < -32'sd1073741824) r = -32'sd1073741824;
        return r;
    endfunction
endpackage

FILE: rtl/rbre_mul.sv
`timescale 1ns / 1ps
// shift-add multiplier, one multiplier bit per cycle, unsigned 64 x 64 -> 128
module rbre_mul
    import rbre_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_mul_ctl      i_ctl,
    input  logic [63:0]   i_a,
    input  logic [63:0]   i_b,
    output t_mul_sts      o_sts,
    output logic [127:0]  o_p
);
    logic [127:0] r_acc, n_acc;
    logic [63:0]  r_mcand, n_mcand;
    logic [63:0]  r_mplier, n_mplier;
    logic [6:0]   r_cnt, n_cnt;
    logic         r_busy, n_busy;
    logic         r_done, n_done;

    always_comb begin
        n_acc = r_acc;
        n_mcand = r_mcand;
        n_mplier = r_mplier;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctl.start) begin
            n_acc = '0;
            n_mcand = i_a;
            n_mplier = i_b;
            n_cnt = 7'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // add the current top bit window: shift right form
            n_acc = {1'b0, r_acc[127:1]};
            if (r_mplier[0]) begin
                n_acc = {1'b0, r_acc[127:64]} + {1'b0, r_mcand} > 0 ?
                    {({1'b0, r_acc[127:64]} + {1'b0, r_mcand}), r_acc[63:1]} :
                    {1'b0, r_acc[127:1]};
            end
            n_mplier = {1'b0, r_mplier[63:1]};
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_acc <= n_acc;
        r_mcand <= n_mcand;
        r_mplier <= n_mplier;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_p = r_acc;
endmodule

FILE: rtl/rbre_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, 64 / 32
module rbre_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    logic [63:0] r_quo, n_quo;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] w_sh;

    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        n_den = r_den;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_sh = {r_rem[31:0], r_quo[63]};
        if (i_start) begin
            n_quo = i_num;
            n_rem = '0;
            n_den = i_den;
            n_cnt = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo = r_quo;
endmodule

FILE: rtl/rigid_body_rotational_energy_sum.sv
`timescale 1ns / 1ps
// channel  dir  tdata bits                                         tuser        tlast
// s_axis   in   shape 3:0, qw..qz 131:4, mx..mz 227:132, mask 259:228 opcode       last_item
// m_axis   out  energy_total 62:0                                  saturated    -
// work: a particle takes 22 serial 64-bit products in the shared multiplier, the rotation
//   and row sums and three divisions; the final scale takes one more product and an
//   output state
// reset: synchronous active low, clears accumulator, flag, control; presets config regs
// stalls: one transaction in work at a time; a result waiting in the output register
//   holds the block only once the next total is ready
module rigid_body_rotational_energy_sum
    import rbre_pkg::*;
#(
    parameter int SHAPE_COUNT = SHAPE_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // shape_index, quat_w, quat_x, quat_y, quat_z, mom_x, mom_y, mom_z, member_mask
    input  logic [263:0]  s_axis_tdata,
    // opcode
    input  logic [0:0]    s_axis_tuser,
    input  logic          s_axis_tlast,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // energy_total
    output logic [63:0]   m_axis_tdata,
    // saturated
    output logic [0:0]    m_axis_tuser
);
    localparam int SW = (SHAPE_COUNT > 1) ? $clog2(SHAPE_COUNT) : 1;

    logic [31:0] r_group, r_scale;
    logic [63:0] r_acc;
    logic        r_flag;
    logic [31:0] r_mem_x [SHAPE_COUNT];
    logic [31:0] r_mem_y [SHAPE_COUNT];
    logic [31:0] r_mem_z [SHAPE_COUNT];

    t_state r_state, n_state;
    logic [263:0] r_in;
    logic         r_op, r_last;
    logic [4:0]   r_step, n_step;
    logic signed [63:0] r_t [0:18];
    logic [31:0]  r_inr [0:2];

    logic         r_ovalid;
    logic [62:0]  r_otot;
    logic         r_osat;

    t_mul_ctl     w_mctl;
    t_mul_sts     w_msts;
    logic [63:0]  w_ma, w_mb;
    logic [127:0] w_mp;
    logic         w_msgn;
    logic         r_msgn;
    logic         w_dstart;
    logic         w_ddone;
    logic [63:0]  w_dnum, w_dquo;
    logic [31:0]  w_dden;

    logic [3:0]        w_shape;
    logic signed [31:0] w_q [0:3];
    logic signed [31:0] w_l [0:2];
    logic [31:0]       w_mask;
    logic [SW-1:0]     w_sidx;
    logic              w_sok;

    assign w_shape = r_in[3:0];
    assign w_q[0] = clampq(r_in[35:4]);
    assign w_q[1] = clampq(r_in[67:36]);
    assign w_q[2] = clampq(r_in[99:68]);
    assign w_q[3] = clampq(r_in[131:100]);
    assign w_l[0] = r_in[163:132];
    assign w_l[1] = r_in[195:164];
    assign w_l[2] = r_in[227:196];
    assign w_mask = r_in[259:228];
    assign w_sidx = SW'(w_shape);
    assign w_sok = ({28'd0, w_shape} < 32'(SHAPE_COUNT));

    // signed operands fed to the unsigned serial multiplier as magnitudes
    logic signed [63:0] w_sa, w_sb;
    logic [63:0] w_abs_a, w_abs_b;
    logic signed [127:0] w_sprod;

    // body momentum magnitude limited to 32 bits before squaring
    function automatic logic signed [63:0] sat_mag(input logic signed [63:0] v);
        logic [63:0] m;
        m = (v < 0) ? 64'(-v) : 64'(v);
        if (m > 64'h0000_0000_FFFF_FFFF) m = 64'h0000_0000_FFFF_FFFF;
        return m;
    endfunction

    // product schedule: steps 0..9 quaternion pairs, 10..18 rotation, 19..21 squares
    always_comb begin
        w_sa = '0;
        w_sb = '0;
        unique case (r_step)
            5'd0: begin w_sa = 64'(w_q[0]); w_sb = 64'(w_q[0]); end
            5'd1: begin w_sa = 64'(w_q[1]); w_sb = 64'(w_q[1]); end
            5'd2: begin w_sa = 64'(w_q[2]); w_sb = 64'(w_q[2]); end
            5'd3: begin w_sa = 64'(w_q[3]); w_sb = 64'(w_q[3]); end
            5'd4: begin w_sa = 64'(w_q[1]); w_sb = 64'(w_q[2]); end
            5'd5: begin w_sa = 64'(w_q[0]); w_sb = 64'(w_q[3]); end
            5'd6: begin w_sa = 64'(w_q[1]); w_sb = 64'(w_q[3]); end
            5'd7: begin w_sa = 64'(w_q[0]); w_sb = 64'(w_q[2]); end
            5'd8: begin w_sa = 64'(w_q[2]); w_sb = 64'(w_q[3]); end
            5'd9: begin w_sa = 64'(w_q[0]); w_sb = 64'(w_q[1]); end
            5'd10: begin w_sa = r_t[0]; w_sb = 64'(w_l[0]); end
            5'd11: begin w_sa = r_t[1]; w_sb = 64'(w_l[1]); end
            5'd12: begin w_sa = r_t[2]; w_sb = 64'(w_l[2]); end
            5'd13: begin w_sa = r_t[3]; w_sb = 64'(w_l[0]); end
            5'd14: begin w_sa = r_t[4]; w_sb = 64'(w_l[1]); end
            5'd15: begin w_sa = r_t[5]; w_sb = 64'(w_l[2]); end
            5'd16: begin w_sa = r_t[6]; w_sb = 64'(w_l[0]); end
            5'd17: begin w_sa = r_t[7]; w_sb = 64'(w_l[1]); end
            5'd18: begin w_sa = r_t[8]; w_sb = 64'(w_l[2]); end
            5'd19: begin w_sa = sat_mag(r_t[9]); w_sb = sat_mag(r_t[9]); end
            5'd20: begin w_sa = sat_mag(r_t[10]); w_sb = sat_mag(r_t[10]); end
            5'd21: begin w_sa = sat_mag(r_t[11]); w_sb = sat_mag(r_t[11]); end
            default: begin w_sa = 64'(r_acc); w_sb = 64'(r_scale); end
        endcase
        w_abs_a = (w_sa < 0 && r_step != 5'd22) ? 64'(-w_sa) : w_sa;
        w_abs_b = (w_sb < 0 && r_step != 5'd22) ? 64'(-w_sb) : w_sb;
        w_msgn = (r_step != 5'd22) && ((w_sa < 0) ^ (w_sb < 0));
        w_ma = w_abs_a;
        w_mb = w_abs_b;
        w_sprod = r_msgn ? -$signed(w_mp) : $signed(w_mp);
    end

    rbre_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_mctl),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_sts  (w_msts),
        .o_p    (w_mp)
    );

    rbre_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_dstart),
        .i_num  (w_dnum),
        .i_den  (w_dden),
        .o_done (w_ddone),
        .o_quo  (w_dquo)
    );

    function automatic logic signed [63:0] fsh(input logic signed [127:0] v, input int s);
        logic signed [127:0] r;
        r = v >>> s;
        return r[63:0];
    endfunction

    logic [1:0] r_k;
    logic       r_mwait;
    logic [63:0] w_sq;
    assign w_sq = w_mp[63:0];
    assign w_dnum = r_t[5'd12 + {3'd0, r_k}];
    assign w_dden = r_inr[r_k];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_mctl.start = (r_state == ST_QMUL || r_state == ST_SCALE) && !r_mwait;
    assign w_dstart = (r_state == ST_DIV) && !r_mwait && (r_inr[r_k] != 32'd0);

    logic signed [63:0] w_ww, w_xx, w_yy, w_zz;
    logic signed [63:0] w_b;
    logic [63:0] w_ab;
    logic [64:0] w_sum;
    always_comb begin
        w_ww = r_t[0]; w_xx = r_t[1]; w_yy = r_t[2]; w_zz = r_t[3];
        w_b = r_t[5'd9 + {3'd0, r_k}];
        w_ab = (w_b < 0) ? 64'(-w_b) : w_b;
        w_sum = {1'b0, r_acc} + {1'b0, w_dquo};
    end

    always_comb begin
        n_state = r_state;
        n_step = r_step;
        unique case (r_state)
            ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_step = '0;
                if (r_op == OP_PART && (w_mask & r_group) != 32'd0) n_state = ST_QMUL;
                else if (r_last) begin n_state = ST_SCALE; n_step = 5'd22; end
                else n_state = ST_IDLE;
            end
            ST_QMUL: if (w_msts.done) begin
                if (r_step == 5'd9) n_state = ST_ROT;
                else if (r_step == 5'd18) n_state = ST_SQR;
                else if (r_step == 5'd21) n_state = ST_DIV;
                else if (r_step == 5'd22) n_state = ST_OUT;
                n_step = r_step + 5'd1;
            end
            ST_ROT: n_state = ST_QMUL;
            ST_SQR: n_state = ST_QMUL;
            ST_DIV: if (r_inr[r_k] == 32'd0 || w_ddone) n_state = ST_ACC;
            ST_ACC: begin
                if (r_k == 2'd2) begin
                    if (r_last) begin n_state = ST_SCALE; n_step = 5'd22; end
                    else n_state = ST_IDLE;
                end else n_state = ST_DIV;
            end
            ST_SCALE: if (w_msts.done) n_state = ST_OUT;
            ST_OUT: if (!r_ovalid || m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step <= '0;
            r_group <= GROUP_RESET;
            r_scale <= SCALE_RESET;
            r_acc <= '0;
            r_flag <= 1'b0;
            r_ovalid <= 1'b0;
            r_mwait <= 1'b0;
            r_k <= '0;
        end else begin
            r_state <= n_state;
            r_step <= n_step;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_GROUP) r_group <= i_cfg_data;
                else r_scale <= i_cfg_data;
            end
            if (r_state == ST_OUT && n_state == ST_IDLE) r_ovalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (w_mctl.start || w_dstart) r_mwait <= 1'b1;
            else if (w_msts.done || r_state == ST_ACC) r_mwait <= 1'b0;
            if (r_state == ST_LOAD) r_k <= '0;
            unique case (r_state)
                ST_LOAD: begin
                    if (r_op == OP_LOAD && w_sok) begin
                        r_mem_x[w_sidx] <= w_l[0];
                        r_mem_y[w_sidx] <= w_l[1];
                        r_mem_z[w_sidx] <= w_l[2];
                    end
                    r_inr[0] <= w_sok ? r_mem_x[w_sidx] : 32'd0;
                    r_inr[1] <= w_sok ? r_mem_y[w_sidx] : 32'd0;
                    r_inr[2] <= w_sok ? r_mem_z[w_sidx] : 32'd0;
                end
                ST_QMUL: if (w_msts.done && r_step <= 5'd21) begin
                    if (r_step <= 5'd18) r_t[r_step] <= fsh(w_sprod, 0);
                    else r_t[r_step - 5'd7] <= w_sq;
                end
                ST_ROT: begin
                    // matrix entries floored to Q.28, stored row-major by L column
                    r_t[0] <= fsh(128'(w_ww + w_xx - w_yy - w_zz), 32);
                    r_t[1] <= fsh(128'(2 * (r_t[4] + r_t[5])), 32);
                    r_t[2] <= fsh(128'(2 * (r_t[6] - r_t[7])), 32);
                    r_t[3] <= fsh(128'(2 * (r_t[4] - r_t[5])), 32);
                    r_t[4] <= fsh(128'(w_ww - w_xx + w_yy - w_zz), 32);
                    r_t[5] <= fsh(128'(2 * (r_t[8] + r_t[9])), 32);
                    r_t[6] <= fsh(128'(2 * (r_t[6] + r_t[7])), 32);
                    r_t[7] <= fsh(128'(2 * (r_t[8] - r_t[9])), 32);
                    r_t[8] <= fsh(128'(w_ww - w_xx - w_yy + w_zz), 32);
                end
                ST_SQR: begin
                    r_t[9]  <= fsh(128'(r_t[10] + r_t[11] + r_t[12]), 28);
                    r_t[10] <= fsh(128'(r_t[13] + r_t[14] + r_t[15]), 28);
                    r_t[11] <= fsh(128'(r_t[16] + r_t[17] + r_t[18]), 28);
                end
                ST_DIV: begin
                    if (w_ab > 64'h0000_0000_FFFF_FFFF) r_flag <= 1'b1;
                end
                ST_ACC: begin
                    r_k <= r_k + 2'd1;
                    if (r_inr[r_k] == 32'd0 || w_sum[64]) begin
                        r_acc <= '1;
                        r_flag <= 1'b1;
                    end else r_acc <= w_sum[63:0];
                end
                ST_OUT: if (n_state == ST_IDLE) begin
                    if (w_mp[127:63] != '0) begin
                        r_otot <= MAX63[62:0];
                        r_osat <= 1'b1;
                    end else begin
                        r_otot <= w_mp[62:0];
                        r_osat <= r_flag;
                    end
                    r_acc <= '0;
                    r_flag <= 1'b0;
                end
                default: ;
            endcase
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= s_axis_tdata;
            r_op <= s_axis_tuser[0];
            r_last <= s_axis_tlast;
        end
        if (w_mctl.start) r_msgn <= w_msgn;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {1'b0, r_otot};
    assign m_axis_tuser = r_osat;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !s_axis_tready) else $error("accept while busy");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_OUT && n_state == ST_IDLE |=> r_acc == '0 && !r_flag)
        else $error("accumulator not cleared");
endmodule
